@@ sv/bffpa_pkg.sv @@
// Package for the bitmap first-fit page allocator.
// Holds sizes, mode and status codes, controller state and the command/status structs.
// No dependencies.
package bffpa_pkg;

   localparam int MaxPages   = 4096;
   localparam int PageBytes  = 4096;
   localparam int PageShift  = 12;
   localparam int MapWords   = (MaxPages + 63) / 64;
   localparam int WordBits   = (MapWords > 1) ? $clog2(MapWords) : 1;
   localparam int IdxBits    = WordBits + 6;
   localparam int CntBits    = 17;

   typedef enum logic [1:0] {
      MODE_INIT  = 2'd0,
      MODE_ALLOC = 2'd1,
      MODE_FREE  = 2'd2,
      MODE_STATS = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_INVALID   = 3'd1,
      ST_NOT_READY = 3'd2,
      ST_NO_PAGES  = 3'd3,
      ST_FRAG      = 3'd4
   } status_type;

   typedef enum logic [0:0] {
      CSR_BASE_PAGE  = 1'b0,
      CSR_POOL_PAGES = 1'b1
   } csr_index_type;

   // walk kinds run by the datapath
   typedef enum logic [2:0] {
      WALK_NONE  = 3'd0,
      WALK_INIT  = 3'd1,
      WALK_FIT   = 3'd2,
      WALK_SET   = 3'd3,
      WALK_CHECK = 3'd4,
      WALK_CLEAR = 3'd5,
      WALK_RUN   = 3'd6
   } walk_type;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_DEC   = 7'b0000010,
      S_WALK1 = 7'b0000100,
      S_MID   = 7'b0001000,
      S_WALK2 = 7'b0010000,
      S_DONE  = 7'b0100000,
      S_OUT   = 7'b1000000
   } state_type;

   typedef struct packed {
      logic     latch;    // capture the item
      logic     start;    // start a walk
      walk_type walk;
      logic     commit;   // apply counter updates for the result
      status_type status;
      logic     load_out;
   } cmd_type;

   typedef struct packed {
      logic       busy;
      logic       found;     // fit found or check failed
      status_type pre_status; // status from the up-front checks
      mode_type   mode;
   } sts_type;

   // ceil(ceil(n/64)*8 / PageBytes)
   function automatic logic [15:0] map_pages_of(input logic [15:0] n);
      logic [16:0] bytes;
      logic [16:0] pg;
      bytes = ({7'd0, n[15:6]} + {16'd0, |n[5:0]}) << 3;
      pg = (bytes + 17'(PageBytes - 1)) >> PageShift;
      return pg[15:0];
   endfunction

endpackage

@@ sv/bffpa_if.sv @@
// Valid/ready channel interfaces for the allocator.
// No dependencies.
interface bffpa_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [63:0] phys_address;
   logic [15:0] page_count;
   modport source (output valid, mode, phys_address, page_count, input ready);
   modport sink   (input valid, mode, phys_address, page_count, output ready);
endinterface

interface bffpa_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [63:0] alloc_address;
   logic [15:0] used_pages;
   logic [15:0] free_pages;
   logic [15:0] peak_pages;
   logic [15:0] largest_free_run;
   modport source (output valid, status, alloc_address, used_pages, free_pages,
                   peak_pages, largest_free_run, input ready);
   modport sink   (input valid, status, alloc_address, used_pages, free_pages,
                   peak_pages, largest_free_run, output ready);
endinterface

interface bffpa_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [63:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/bffpa_ram.sv @@
// Generic single-port RAM with registered read.
// No dependencies.
module bffpa_ram #(
   parameter int Width = 64,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wdata,
   output logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule

@@ sv/bffpa_ctrl.sv @@
// Controller state machine of the allocator.
// Depends on bffpa_pkg; drives the datapath through cmd_type.
module bffpa_ctrl import bffpa_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  logic    out_busy,
   input  sts_type sts,
   output cmd_type cmd
);
   state_type  state_ff, state_in;
   status_type stat_ff, stat_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         stat_ff  <= ST_OK;
      end else begin
         state_ff <= state_in;
         stat_ff  <= stat_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      stat_in  = stat_ff;
      cmd      = '0;
      cmd.walk = WALK_NONE;
      cmd.status = stat_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_DEC;
            end
         end
         // up-front checks settle status or pick the first walk
         S_DEC: begin
            stat_in = sts.pre_status;
            if (sts.pre_status != ST_OK) begin
               state_in = S_DONE;
            end else begin
               cmd.start = 1'b1;
               state_in  = S_WALK1;
               case (sts.mode)
                  MODE_INIT:  cmd.walk = WALK_INIT;
                  MODE_ALLOC: cmd.walk = WALK_FIT;
                  MODE_FREE:  cmd.walk = WALK_CHECK;
                  MODE_STATS: cmd.walk = WALK_RUN;
                  default:    cmd.walk = WALK_NONE;
               endcase
            end
         end
         S_WALK1: begin
            if (!sts.busy) begin
               state_in = S_MID;
            end
         end
         S_MID: begin
            state_in = S_DONE;
            if (sts.mode == MODE_ALLOC) begin
               if (sts.found) begin
                  cmd.start = 1'b1;
                  cmd.walk  = WALK_SET;
                  state_in  = S_WALK2;
               end else begin
                  stat_in = ST_FRAG;
               end
            end else if (sts.mode == MODE_FREE) begin
               if (sts.found) begin
                  stat_in = ST_NOT_READY;
               end else begin
                  cmd.start = 1'b1;
                  cmd.walk  = WALK_CLEAR;
                  state_in  = S_WALK2;
               end
            end
         end
         S_WALK2: begin
            if (!sts.busy) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            cmd.commit = 1'b1;
            state_in   = S_OUT;
         end
         S_OUT: begin
            if (!out_busy) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule

@@ sv/bffpa_dp.sv @@
// Datapath of the allocator: item registers, counters, map walker and RAM.
// Depends on bffpa_pkg and bffpa_ram.
module bffpa_dp import bffpa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic [1:0]  in_mode,
   input  logic [63:0] in_addr,
   input  logic [15:0] in_count,
   input  logic [51:0] base_page,
   input  logic [15:0] pool_pages,
   input  cmd_type     cmd,
   output sts_type     sts,
   output logic [2:0]  o_status,
   output logic [63:0] o_address,
   output logic [15:0] o_used,
   output logic [15:0] o_free,
   output logic [15:0] o_peak,
   output logic [15:0] o_run
);
   // item registers
   mode_type     mode_ff;
   logic [63:0]  addr_ff;
   logic [15:0]  cnt_ff;
   // pool state
   logic         ready_ff;
   logic [15:0]  usable_ff, used_ff, peak_ff, total_ff;
   logic [63:0]  pbase_ff;
   logic [15:0]  newmap_ff, newtotal_ff;
   logic [63:0]  newbase_ff;
   // walker
   walk_type     walk_ff;
   logic         busy_ff, rd_ff, found_ff;
   logic [WordBits:0] word_ff;
   logic [2:0]   sub_ff;                // byte of the word under scan
   logic [IdxBits-1:0] lo_ff, hi_ff;   // bit range [lo, hi)
   logic [IdxBits-1:0] start_ff, fit_ff;
   logic [CntBits-1:0] run_ff, best_ff;

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         mode_ff <= mode_type'(in_mode);
         addr_ff <= in_addr;
         cnt_ff  <= in_count;
      end
   end

   // up-front checks
   logic [15:0] mp;
   logic [63:0] off;
   logic [63:0] lim;
   logic [16:0] idx_end;
   status_type  pre;
   assign mp  = map_pages_of(pool_pages);
   assign off = addr_ff - pbase_ff;
   assign lim = {36'd0, total_ff, 12'd0};
   assign idx_end = {1'b0, off[27:12]} + {1'b0, cnt_ff};

   always_comb begin
      pre = ST_OK;
      case (mode_ff)
         MODE_INIT: begin
            if (base_page == '0 || pool_pages == '0 || pool_pages > 16'(MaxPages)
                || mp >= pool_pages) pre = ST_INVALID;
         end
         MODE_ALLOC: begin
            if (!ready_ff) pre = ST_NOT_READY;
            else if (cnt_ff == '0 || cnt_ff > usable_ff) pre = ST_INVALID;
            else if (used_ff > usable_ff || (usable_ff - used_ff) < cnt_ff)
               pre = ST_NO_PAGES;
         end
         MODE_FREE: begin
            if (!ready_ff) pre = ST_NOT_READY;
            else if (cnt_ff == '0 || addr_ff < pbase_ff || off >= lim
                     || addr_ff[11:0] != '0 || idx_end > {1'b0, usable_ff})
               pre = ST_INVALID;
         end
         default: pre = ST_OK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.start && cmd.walk == WALK_INIT) begin
         newmap_ff   <= mp;
         newtotal_ff <= pool_pages;
         newbase_ff  <= {base_page, 12'd0};
      end
   end

   // map RAM
   logic              ram_we;
   logic [WordBits-1:0] ram_addr;
   logic [63:0]       ram_wdata, ram_rdata;
   logic [63:0]       mask;

   bffpa_ram #(.Width(64), .Depth(MapWords)) u_map (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // bits of the current word that fall in [lo, hi)
   logic [IdxBits-1:0] wbase;
   assign wbase = {word_ff[WordBits-1:0], 6'd0};
   always_comb begin
      for (int b = 0; b < 64; b++) begin
         mask[b] = ({1'b0, wbase} + (IdxBits+1)'(b) >= {1'b0, lo_ff})
                && ({1'b0, wbase} + (IdxBits+1)'(b) < {1'b0, hi_ff});
      end
   end

   // run scan of one byte of the word per cycle, once the word has been read
   logic [IdxBits-1:0] cbase;
   assign cbase = wbase + {{(IdxBits-6){1'b0}}, sub_ff, 3'd0};

   logic [CntBits-1:0] run_n, best_n;
   logic [IdxBits-1:0] start_n, fit_n;
   logic               found_n;
   always_comb begin
      run_n = run_ff; best_n = best_ff; start_n = start_ff;
      fit_n = fit_ff; found_n = found_ff;
      for (int b = 0; b < 8; b++) begin
         if (mask[{sub_ff, 3'(b)}] && !found_n) begin
            if (!ram_rdata[{sub_ff, 3'(b)}]) begin
               // a free page inside a range to free is a double free
               if (walk_ff == WALK_CHECK) found_n = 1'b1;
               if (run_n == '0) start_n = cbase + IdxBits'(b);
               run_n = run_n + 1'b1;
               if (run_n > best_n) best_n = run_n;
               if (walk_ff == WALK_FIT && run_n == {1'b0, cnt_ff}) begin
                  found_n = 1'b1;
                  fit_n   = start_n;
               end
            end else begin
               run_n = '0;
            end
         end
      end
   end

   logic last_word;
   logic last_chunk;
   assign last_word  = ({1'b0, wbase} + (IdxBits+1)'(64) >= {1'b0, hi_ff});
   assign last_chunk = ({1'b0, cbase} + (IdxBits+1)'(8) >= {1'b0, hi_ff});

   always_comb begin
      ram_addr  = word_ff[WordBits-1:0];
      ram_we    = 1'b0;
      ram_wdata = ram_rdata;
      if (busy_ff) begin
         case (walk_ff)
            WALK_INIT: begin
               ram_we    = 1'b1;
               ram_wdata = mask;
            end
            WALK_SET: begin
               ram_we    = rd_ff;
               ram_wdata = ram_rdata | mask;
            end
            WALK_CLEAR: begin
               ram_we    = rd_ff;
               ram_wdata = ram_rdata & ~mask;
            end
            default: ram_we = 1'b0;
         endcase
      end
   end

   // walker control: set and clear read each word and then write it back,
   // scans read each word and then scan it a byte at a time
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         rd_ff   <= 1'b0;
      end else if (cmd.start) begin
         busy_ff  <= 1'b1;
         rd_ff    <= 1'b0;
         walk_ff  <= cmd.walk;
         sub_ff   <= '0;
         run_ff   <= '0;
         best_ff  <= '0;
         found_ff <= 1'b0;
         start_ff <= '0;
         if (cmd.walk != WALK_SET) fit_ff <= '0;
         case (cmd.walk)
            WALK_INIT: begin
               word_ff <= '0;
               lo_ff <= '0; hi_ff <= mp[IdxBits-1:0];
            end
            WALK_FIT, WALK_RUN: begin
               word_ff <= '0;
               lo_ff <= '0; hi_ff <= usable_ff[IdxBits-1:0];
            end
            WALK_SET: begin
               word_ff <= {1'b0, fit_ff[IdxBits-1:6]};
               lo_ff <= fit_ff; hi_ff <= fit_ff + cnt_ff[IdxBits-1:0];
            end
            default: begin
               word_ff <= {1'b0, off[IdxBits+11:18]};
               lo_ff <= off[IdxBits+11:12];
               hi_ff <= off[IdxBits+11:12] + cnt_ff[IdxBits-1:0];
            end
         endcase
      end else if (busy_ff) begin
         if (walk_ff == WALK_INIT) begin
            word_ff <= word_ff + 1'b1;
            if (word_ff == (WordBits+1)'(MapWords - 1)) busy_ff <= 1'b0;
         end else if (!rd_ff) begin
            rd_ff <= 1'b1;
         end else if (walk_ff == WALK_SET || walk_ff == WALK_CLEAR) begin
            rd_ff   <= 1'b0;
            word_ff <= word_ff + 1'b1;
            if (last_word || word_ff == (WordBits+1)'(MapWords - 1))
               busy_ff <= 1'b0;
         end else begin
            run_ff <= run_n; best_ff <= best_n; start_ff <= start_n;
            fit_ff <= fit_n; found_ff <= found_n;
            if (last_chunk || found_n
                || (word_ff == (WordBits+1)'(MapWords - 1) && sub_ff == 3'd7)) begin
               busy_ff <= 1'b0;
            end else if (sub_ff == 3'd7) begin
               sub_ff  <= '0;
               rd_ff   <= 1'b0;
               word_ff <= word_ff + 1'b1;
            end else begin
               sub_ff <= sub_ff + 1'b1;
            end
         end
      end
   end

   assign sts.busy       = busy_ff;
   assign sts.found      = found_ff;
   assign sts.pre_status = pre;
   assign sts.mode       = mode_ff;

   // pool counters
   logic [16:0] used_add;
   assign used_add = {1'b0, used_ff} + {1'b0, cnt_ff};
   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff  <= 1'b0;
         usable_ff <= '0;
         used_ff   <= '0;
         peak_ff   <= '0;
         total_ff  <= '0;
         pbase_ff  <= '0;
      end else if (cmd.commit && cmd.status == ST_OK) begin
         case (mode_ff)
            MODE_INIT: begin
               ready_ff  <= 1'b1;
               usable_ff <= newtotal_ff - newmap_ff;
               used_ff   <= newmap_ff;
               peak_ff   <= '0;
               total_ff  <= newtotal_ff;
               pbase_ff  <= newbase_ff;
            end
            MODE_ALLOC: begin
               used_ff <= used_add[15:0];
               if (used_add[15:0] > peak_ff) peak_ff <= used_add[15:0];
            end
            MODE_FREE: used_ff <= (used_ff >= cnt_ff) ? used_ff - cnt_ff : '0;
            default: ;
         endcase
      end
   end

   // result fields, valid after commit
   logic [63:0] addr_ok;
   assign addr_ok = pbase_ff + {{(64-IdxBits-12){1'b0}}, fit_ff, 12'd0};
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         o_status  <= cmd.status;
         o_address <= (cmd.status == ST_OK && mode_ff == MODE_ALLOC) ? addr_ok : '0;
         o_run     <= (mode_ff == MODE_STATS && ready_ff) ? best_ff[15:0] : '0;
      end
   end
   assign o_used = ready_ff ? used_ff : '0;
   assign o_free = (ready_ff && used_ff <= usable_ff) ? usable_ff - used_ff : '0;
   assign o_peak = ready_ff ? peak_ff : '0;
endmodule

@@ sv/bitmap_first_fit_page_allocator.sv @@
// Bitmap first-fit page allocator, top level.
// Init writes every map word; alloc and stats scan the map and free checks its range,
// reading each word and then scanning it a byte at a time; alloc and free then set or
// clear the range, reading and writing back each word; the result is held until taken.
// One item at a time; the next item is taken the cycle after the result is loaded.
// Synchronous reset clears the counters and the ready flag; init writes the map.
// Depends on bffpa_pkg, bffpa_if, bffpa_ctrl and bffpa_dp.
module bitmap_first_fit_page_allocator import bffpa_pkg::*; (
   input  logic clock,
   input  logic reset,
   bffpa_req_if.sink   req,
   bffpa_rsp_if.source rsp,
   bffpa_csr_if.sink   csr
);
   logic [51:0] base_page_ff;
   logic [15:0] pool_pages_ff;
   cmd_type     cmd;
   sts_type     sts;
   logic        rsp_valid_ff;
   logic [2:0]  o_status;
   logic [63:0] o_address;
   logic [15:0] o_used, o_free, o_peak, o_run;

   // configuration registers
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         base_page_ff  <= '0;
         pool_pages_ff <= '0;
      end else if (csr.valid) begin
         case (csr_index_type'(csr.index))
            CSR_BASE_PAGE:  base_page_ff  <= csr.data[51:0];
            CSR_POOL_PAGES: pool_pages_ff <= csr.data[15:0];
            default: ;
         endcase
      end
   end

   bffpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .out_busy  (rsp_valid_ff),
      .sts       (sts),
      .cmd       (cmd)
   );

   bffpa_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .in_mode    (req.mode),
      .in_addr    (req.phys_address),
      .in_count   (req.page_count),
      .base_page  (base_page_ff),
      .pool_pages (pool_pages_ff),
      .cmd        (cmd),
      .sts        (sts),
      .o_status   (o_status),
      .o_address  (o_address),
      .o_used     (o_used),
      .o_free     (o_free),
      .o_peak     (o_peak),
      .o_run      (o_run)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp.status           <= o_status;
         rsp.alloc_address    <= o_address;
         rsp.used_pages       <= o_used;
         rsp.free_pages       <= o_free;
         rsp.peak_pages       <= o_peak;
         rsp.largest_free_run <= o_run;
      end
   end
   assign rsp.valid = rsp_valid_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |-> !cmd.load_out) else $error("result overwritten");
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.status != ST_OK |-> rsp.alloc_address == '0)
      else $error("address on failure");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      sts.busy |-> !req.ready) else $error("item taken mid walk");
endmodule
